// ===== rtl/core/pct_pkg.sv =====
// package: item types, codes and control/status structs for the command tracker
`timescale 1ns / 1ps
package pct_pkg;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int BUSY_DEPTH_DEF = 8;
  localparam int MAX_RESULTS    = 25;
  localparam int RES_W          = 5;
  localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

  // event kinds
  localparam logic [2:0] FUNC_SUBMIT   = 3'd0;
  localparam logic [2:0] FUNC_RESPONSE = 3'd1;
  localparam logic [2:0] FUNC_TICK     = 3'd2;
  localparam logic [2:0] FUNC_READY    = 3'd3;
  localparam logic [2:0] FUNC_CANCEL   = 3'd4;

  // priority classes
  localparam logic [1:0] CLS_QUEUED    = 2'd0;
  localparam logic [1:0] CLS_FASTPASS  = 2'd1;
  localparam logic [1:0] CLS_KEEPALIVE = 2'd2;
  localparam logic [1:0] CLS_INVALID   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_COMP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // completion outcomes
  localparam logic [1:0] OUT_RESPONDED = 2'd0;
  localparam logic [1:0] OUT_TIMEDOUT  = 2'd1;
  localparam logic [1:0] OUT_CANCELED  = 2'd2;
  localparam logic [1:0] OUT_REJECTED  = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] cmd_id;
    logic [1:0]  prio_class;
    logic        ready_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_id;
    logic [1:0]  outcome;
    logic        accepted;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ID_CMD,
    ID_BUSY,
    ID_WAIT,
    ID_ZERO
  } id_src_t;

  typedef struct packed {
    logic       load;
    logic       ins;
    logic       rm_busy;
    logic       rm_at_hit;
    logic       send;
    logic       clr_busy;
    logic       clr_wait;
    logic       gate_wr;
    logic       bidx_clr;
    logic       bidx_inc;
    logic       widx_clr;
    logic       widx_inc;
    logic       emit;
    logic       emit_last;
    id_src_t    id_src;
    logic [1:0] kind;
    logic [1:0] outcome;
  } pct_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       level;
    logic       rej;
    logic       hit;
    logic       bvalid;
    logic       tmo;
    logic       wvalid;
    logic       send_ok;
    logic       emit_ok;
    logic       out_free;
  } pct_status_t;

endpackage

// ===== rtl/core/pct_ctrl.sv =====
// controller: sequences the table operations and result items of one event
`timescale 1ns / 1ps
module pct_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pct_pkg::pct_status_t st,
  output pct_pkg::pct_cmd_t    cmd
);
  import pct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REJ,
    S_RESP,
    S_TICK,
    S_PUMP,
    S_CXB,
    S_CXW,
    S_STAT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.id_src = ID_CMD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.func)
          FUNC_SUBMIT: begin
            if (st.rej) begin
              state_next = S_REJ;
            end else begin
              cmd.ins = 1'b1;
              cmd.widx_clr = 1'b1;
              state_next = S_PUMP;
            end
          end
          FUNC_RESPONSE: begin
            state_next = st.hit ? S_RESP : S_STAT;
          end
          FUNC_TICK: begin
            cmd.bidx_clr = 1'b1;
            state_next = S_TICK;
          end
          FUNC_READY: begin
            cmd.gate_wr = 1'b1;
            cmd.widx_clr = 1'b1;
            state_next = st.level ? S_PUMP : S_STAT;
          end
          FUNC_CANCEL: begin
            cmd.bidx_clr = 1'b1;
            state_next = S_CXB;
          end
          default: begin
            state_next = S_STAT;
          end
        endcase
      end
      S_REJ: begin
        cmd.kind = KIND_COMP;
        cmd.outcome = OUT_REJECTED;
        if (st.emit_ok) begin
          cmd.emit = 1'b1;
          state_next = S_STAT;
        end
      end
      S_RESP: begin
        cmd.kind = KIND_COMP;
        cmd.outcome = OUT_RESPONDED;
        if (st.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.rm_busy = 1'b1;
          cmd.rm_at_hit = 1'b1;
          cmd.widx_clr = 1'b1;
          state_next = S_PUMP;
        end
      end
      S_TICK: begin
        cmd.kind = KIND_COMP;
        cmd.outcome = OUT_TIMEDOUT;
        cmd.id_src = ID_BUSY;
        if (!st.bvalid) begin
          cmd.widx_clr = 1'b1;
          state_next = S_PUMP;
        end else if (!st.tmo) begin
          cmd.bidx_inc = 1'b1;
        end else if (st.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.rm_busy = 1'b1;
        end
      end
      S_PUMP: begin
        cmd.kind = KIND_SEND;
        cmd.id_src = ID_WAIT;
        if (!st.wvalid) begin
          state_next = S_STAT;
        end else if (!st.send_ok) begin
          cmd.widx_inc = 1'b1;
        end else if (st.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.send = 1'b1;
          cmd.widx_clr = 1'b1;
        end
      end
      S_CXB: begin
        cmd.kind = KIND_COMP;
        cmd.outcome = OUT_CANCELED;
        cmd.id_src = ID_BUSY;
        if (!st.bvalid) begin
          cmd.clr_busy = 1'b1;
          cmd.widx_clr = 1'b1;
          state_next = S_CXW;
        end else if (st.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.bidx_inc = 1'b1;
        end
      end
      S_CXW: begin
        cmd.kind = KIND_COMP;
        cmd.outcome = OUT_CANCELED;
        cmd.id_src = ID_WAIT;
        if (!st.wvalid) begin
          cmd.clr_wait = 1'b1;
          state_next = S_STAT;
        end else if (st.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.widx_inc = 1'b1;
        end
      end
      S_STAT: begin
        cmd.kind = KIND_STATUS;
        cmd.emit_last = 1'b1;
        cmd.id_src = (st.func == FUNC_SUBMIT || st.func == FUNC_RESPONSE) ? ID_CMD : ID_ZERO;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/pct_dpath.sv =====
// datapath: wait list, in-flight table, scan indexes and output register
`timescale 1ns / 1ps
module pct_dpath #(
  parameter int WAIT_DEPTH = pct_pkg::WAIT_DEPTH_DEF,
  parameter int BUSY_DEPTH = pct_pkg::BUSY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pct_pkg::in_item_t    in_item,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  pct_pkg::pct_cmd_t    cmd,
  output pct_pkg::pct_status_t st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pct_pkg::out_item_t   out_item
);
  import pct_pkg::*;

  localparam int BW  = $clog2(BUSY_DEPTH + 1);
  localparam int WW  = $clog2(WAIT_DEPTH + 1);
  localparam int BIW = $clog2(BUSY_DEPTH);
  localparam int WIW = $clog2(WAIT_DEPTH);

  in_item_t                cur;
  logic [15:0]             wait_ids     [WAIT_DEPTH];
  logic [1:0]              wait_classes [WAIT_DEPTH];
  logic [WW-1:0]           wait_count;
  logic [15:0]             busy_ids     [BUSY_DEPTH];
  logic [1:0]              busy_classes [BUSY_DEPTH];
  logic [31:0]             busy_time    [BUSY_DEPTH];
  logic [BUSY_DEPTH-1:0]   busy_valid;
  logic                    ready_gate;
  logic [31:0]             timeout_ms;
  logic [BW-1:0]           bidx;
  logic [WW-1:0]           widx;
  logic [BIW-1:0]          hit_idx;
  logic                    rej;
  logic                    hit;
  logic                    acc;
  logic [RES_W-1:0]        res_cnt;

  logic [15:0]    b_id;
  logic [31:0]    b_time;
  logic [15:0]    w_id;
  logic [1:0]     w_cls;
  logic [BW-1:0]  bcount;
  logic           bvalid;
  logic           wvalid;
  logic           any_queued;
  logic           w_in_busy;
  logic           send_ok;
  logic           in_bhit;
  logic           in_whit;
  logic [BIW-1:0] in_hit_idx;
  logic           rej_in;
  logic           drop;
  logic           out_free;
  logic           do_load;
  logic [BIW-1:0] rm_pos;
  logic [15:0]    emit_id;

  // reads at the scan indexes
  assign bvalid = (bidx < BW'(BUSY_DEPTH)) && busy_valid[bidx[BIW-1:0]];
  assign wvalid = (widx < wait_count);
  assign b_id   = busy_ids[bidx[BIW-1:0]];
  assign b_time = busy_time[bidx[BIW-1:0]];
  assign w_id   = wait_ids[widx[WIW-1:0]];
  assign w_cls  = wait_classes[widx[WIW-1:0]];
  assign bcount = BW'($countones(busy_valid));

  // send gate for the wait entry under the scan index
  always_comb begin
    any_queued = 1'b0;
    w_in_busy  = 1'b0;
    for (int i = 0; i < BUSY_DEPTH; i++) begin
      if (busy_valid[i] && busy_classes[i] == CLS_QUEUED) any_queued = 1'b1;
      if (busy_valid[i] && busy_ids[i] == w_id) w_in_busy = 1'b1;
    end
    send_ok = !busy_valid[BUSY_DEPTH-1] && !w_in_busy &&
              (w_cls != CLS_QUEUED || (ready_gate && !any_queued));
  end

  // duplicate and match checks against the incoming item
  always_comb begin
    in_bhit    = 1'b0;
    in_whit    = 1'b0;
    in_hit_idx = '0;
    for (int i = BUSY_DEPTH - 1; i >= 0; i--) begin
      if (busy_valid[i] && busy_ids[i] == in_item.cmd_id) begin
        in_bhit    = 1'b1;
        in_hit_idx = BIW'(i);
      end
    end
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      if (WW'(i) < wait_count && wait_ids[i] == in_item.cmd_id) in_whit = 1'b1;
    end
    rej_in = (in_item.prio_class == CLS_INVALID) || in_bhit || in_whit ||
             (wait_count == WW'(WAIT_DEPTH));
  end

  // output register handshake
  assign out_free = !out_valid || !out_stall;
  assign drop     = (res_cnt >= RES_W'(MAX_RESULTS - 1));
  assign do_load  = cmd.emit && (cmd.emit_last || !drop);
  assign rm_pos   = cmd.rm_at_hit ? hit_idx : bidx[BIW-1:0];

  always_comb begin
    case (cmd.id_src)
      ID_CMD:  emit_id = cur.cmd_id;
      ID_BUSY: emit_id = b_id;
      ID_WAIT: emit_id = w_id;
      default: emit_id = '0;
    endcase
  end

  assign st.func     = cur.func;
  assign st.level    = cur.ready_level;
  assign st.rej      = rej;
  assign st.hit      = hit;
  assign st.bvalid   = bvalid;
  assign st.tmo      = (cur.now_ms - b_time) >= timeout_ms;
  assign st.wvalid   = wvalid;
  assign st.send_ok  = send_ok;
  assign st.emit_ok  = drop || out_free;
  assign st.out_free = out_free;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count <= '0;
      busy_valid <= '0;
      ready_gate <= 1'b0;
      timeout_ms <= TIMEOUT_RESET;
      out_valid  <= 1'b0;
      res_cnt    <= '0;
      bidx       <= '0;
      widx       <= '0;
    end else begin
      if (cfg_wr_en) timeout_ms <= cfg_wr_data;
      if (cmd.gate_wr) ready_gate <= cur.ready_level;

      if (do_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.load) begin
        res_cnt <= '0;
      end else if (do_load) begin
        res_cnt <= res_cnt + RES_W'(1);
      end

      if (cmd.bidx_clr) begin
        bidx <= '0;
      end else if (cmd.bidx_inc) begin
        bidx <= bidx + BW'(1);
      end

      if (cmd.widx_clr) begin
        widx <= '0;
      end else if (cmd.widx_inc) begin
        widx <= widx + WW'(1);
      end

      if (cmd.clr_busy) begin
        busy_valid <= '0;
      end else if (cmd.rm_busy) begin
        busy_valid <= busy_valid >> 1;
      end else if (cmd.send) begin
        busy_valid <= {busy_valid[BUSY_DEPTH-2:0], 1'b1};
      end

      if (cmd.clr_wait) begin
        wait_count <= '0;
      end else if (cmd.ins) begin
        wait_count <= wait_count + WW'(1);
      end else if (cmd.send) begin
        wait_count <= wait_count - WW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur     <= in_item;
      rej     <= rej_in;
      hit     <= in_bhit;
      hit_idx <= in_hit_idx;
      if (in_item.func == FUNC_SUBMIT) begin
        acc <= !rej_in;
      end else if (in_item.func == FUNC_RESPONSE) begin
        acc <= in_bhit;
      end else begin
        acc <= 1'b1;
      end
    end

    if (do_load) begin
      out_item.kind     <= cmd.kind;
      out_item.out_id   <= emit_id;
      out_item.outcome  <= cmd.outcome;
      out_item.accepted <= cmd.emit_last ? acc : 1'b0;
      out_item.last     <= cmd.emit_last;
    end

    // in-flight table: compact on removal, append on send
    if (cmd.rm_busy) begin
      for (int i = 0; i < BUSY_DEPTH - 1; i++) begin
        if (BIW'(i) >= rm_pos) begin
          busy_ids[i]     <= busy_ids[i+1];
          busy_classes[i] <= busy_classes[i+1];
          busy_time[i]    <= busy_time[i+1];
        end
      end
    end else if (cmd.send) begin
      for (int i = 0; i < BUSY_DEPTH; i++) begin
        if (BW'(i) == bcount) begin
          busy_ids[i]     <= w_id;
          busy_classes[i] <= w_cls;
          busy_time[i]    <= cur.now_ms;
        end
      end
    end

    // wait list: insert at head or tail, close the gap on send
    if (cmd.ins) begin
      if (cur.prio_class == CLS_KEEPALIVE) begin
        for (int i = 1; i < WAIT_DEPTH; i++) begin
          wait_ids[i]     <= wait_ids[i-1];
          wait_classes[i] <= wait_classes[i-1];
        end
        wait_ids[0]     <= cur.cmd_id;
        wait_classes[0] <= cur.prio_class;
      end else begin
        for (int i = 0; i < WAIT_DEPTH; i++) begin
          if (WW'(i) == wait_count) begin
            wait_ids[i]     <= cur.cmd_id;
            wait_classes[i] <= cur.prio_class;
          end
        end
      end
    end else if (cmd.send) begin
      for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
        if (WW'(i) >= widx) begin
          wait_ids[i]     <= wait_ids[i+1];
          wait_classes[i] <= wait_classes[i+1];
        end
      end
    end
  end

endmodule

// ===== rtl/core/priority_command_tracker.sv =====
// top level: command tracker with priority classes, controller plus datapath
`timescale 1ns / 1ps
// Tracks commands by correlation id over a wait list and an in-flight table.
// One event is taken at a time; in_stall stays high until its final status
// item has been loaded into the output register. An event is latched and
// dispatched, then steps through its result items, the in-flight entries
// visited by a tick or cancel and the wait entries visited by the send scan;
// every send restarts that scan from the head, as the wait list has a single
// scan index. The shortest events (set ready low, unmatched response, unknown
// kind) go from dispatch straight to their status item. A stalled output
// holds the sequencer at each step that loads a result item, unless that item
// is dropped past the result limit. The timeout register may be written at
// any idle time and resets to 3000.
module priority_command_tracker #(
  parameter int WAIT_DEPTH = pct_pkg::WAIT_DEPTH_DEF,
  parameter int BUSY_DEPTH = pct_pkg::BUSY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pct_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import pct_pkg::*;

  pct_cmd_t    cmd;
  pct_status_t st;

  // sequencer
  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // tables and output register
  pct_dpath #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .BUSY_DEPTH (BUSY_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== sim/tb_priority_command_tracker.sv =====
// testbench: random and directed event stream checked against a behavioral tracker model
`timescale 1ns / 1ps
module tb_priority_command_tracker;
  import pct_pkg::*;

  localparam int WD = WAIT_DEPTH_DEF;
  localparam int BD = BUSY_DEPTH_DEF;

  // behavioral tracker with an expected-result queue
  class tracker_board;
    logic [15:0] w_id[WD];
    logic [1:0]  w_cls[WD];
    int          w_n;
    logic [15:0] b_id[BD];
    logic [1:0]  b_cls[BD];
    logic [31:0] b_time[BD];
    int          b_n;
    bit          gate;
    logic [31:0] tmo;
    out_item_t   pending[$];
    int          errors;
    int          checked;

    function new();
      w_n = 0; b_n = 0; gate = 0; tmo = TIMEOUT_RESET; errors = 0; checked = 0;
    endfunction

    function void push(logic [1:0] k, logic [15:0] id, logic [1:0] oc, bit acc, bit lst);
      out_item_t r;
      r.kind = k; r.out_id = id; r.outcome = oc; r.accepted = acc; r.last = lst;
      pending = {pending, r};
    endfunction

    function bit busy_has(logic [15:0] id);
      for (int i = 0; i < b_n; i++) if (b_id[i] == id) return 1;
      return 0;
    endfunction

    function void busy_drop(int k);
      for (int i = k; i + 1 < b_n; i++) begin
        b_id[i] = b_id[i+1]; b_cls[i] = b_cls[i+1]; b_time[i] = b_time[i+1];
      end
      b_n--;
    endfunction

    function bit sendable(int w);
      if (b_n >= BD || busy_has(w_id[w])) return 0;
      if (w_cls[w] != CLS_QUEUED) return 1;
      if (!gate) return 0;
      for (int i = 0; i < b_n; i++) if (b_cls[i] == CLS_QUEUED) return 0;
      return 1;
    endfunction

    function void dispatch(logic [31:0] now);
      bit moved;
      moved = 1;
      while (moved) begin
        moved = 0;
        for (int w = 0; w < w_n; w++) begin
          if (sendable(w)) begin
            b_id[b_n] = w_id[w]; b_cls[b_n] = w_cls[w]; b_time[b_n] = now; b_n++;
            push(KIND_SEND, w_id[w], 2'd0, 0, 0);
            for (int i = w; i + 1 < w_n; i++) begin
              w_id[i] = w_id[i+1]; w_cls[i] = w_cls[i+1];
            end
            w_n--;
            moved = 1;
            break;
          end
        end
      end
    endfunction

    // predict all results of one accepted item
    function void note_event(in_item_t it);
      bit dup, hit;
      int k;
      case (it.func)
        FUNC_SUBMIT: begin
          dup = busy_has(it.cmd_id);
          for (int i = 0; i < w_n; i++) if (w_id[i] == it.cmd_id) dup = 1;
          if (it.prio_class == CLS_INVALID || dup || w_n >= WD) begin
            push(KIND_COMP, it.cmd_id, OUT_REJECTED, 0, 0);
            push(KIND_STATUS, it.cmd_id, 2'd0, 0, 1);
          end else begin
            if (it.prio_class == CLS_KEEPALIVE) begin
              for (int i = w_n; i > 0; i--) begin
                w_id[i] = w_id[i-1]; w_cls[i] = w_cls[i-1];
              end
              w_id[0] = it.cmd_id; w_cls[0] = it.prio_class;
            end else begin
              w_id[w_n] = it.cmd_id; w_cls[w_n] = it.prio_class;
            end
            w_n++;
            dispatch(it.now_ms);
            push(KIND_STATUS, it.cmd_id, 2'd0, 1, 1);
          end
        end
        FUNC_RESPONSE: begin
          hit = 0;
          for (k = 0; k < b_n; k++) if (b_id[k] == it.cmd_id) begin hit = 1; break; end
          if (hit) begin
            busy_drop(k);
            push(KIND_COMP, it.cmd_id, OUT_RESPONDED, 0, 0);
            dispatch(it.now_ms);
          end
          push(KIND_STATUS, it.cmd_id, 2'd0, hit, 1);
        end
        FUNC_TICK: begin
          k = 0;
          while (k < b_n) begin
            if (32'(it.now_ms - b_time[k]) >= tmo) begin
              push(KIND_COMP, b_id[k], OUT_TIMEDOUT, 0, 0);
              busy_drop(k);
            end else k++;
          end
          dispatch(it.now_ms);
          push(KIND_STATUS, 16'd0, 2'd0, 1, 1);
        end
        FUNC_READY: begin
          gate = it.ready_level;
          if (gate) dispatch(it.now_ms);
          push(KIND_STATUS, 16'd0, 2'd0, 1, 1);
        end
        FUNC_CANCEL: begin
          for (int i = 0; i < b_n; i++) push(KIND_COMP, b_id[i], OUT_CANCELED, 0, 0);
          for (int i = 0; i < w_n; i++) push(KIND_COMP, w_id[i], OUT_CANCELED, 0, 0);
          b_n = 0; w_n = 0;
          push(KIND_STATUS, 16'd0, 2'd0, 1, 1);
        end
        default: push(KIND_STATUS, 16'd0, 2'd0, 1, 1);
      endcase
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", got.kind, got.out_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.out_id !== e.out_id) begin
        $error("out_id: expected %0d actual %0d", e.out_id, got.out_id); errors++;
      end
      if (got.outcome !== e.outcome) begin
        $error("outcome: expected %0d actual %0d", e.outcome, got.outcome); errors++;
      end
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d actual %0d", e.accepted, got.accepted); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_item;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;

  tracker_board board;
  bit          calm = 0;     // no idling on either side
  int          hold_cycles = 0;
  int          sent_items = 0;
  logic [31:0] clock_ms = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  priority_command_tracker u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // result side: random stalls, a long hold-off on request
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_item);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1;
      end else out_stall <= (!calm && $urandom_range(99) < 14);
    end
  end

  // offer one item and wait until the block takes it; valid drops only on idle
  task automatic send_event(in_item_t it);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_event(it);
    sent_items++;
  endtask

  task automatic ev(logic [2:0] f, logic [15:0] id, logic [1:0] c, bit lv, logic [31:0] now);
    in_item_t it;
    it.func = f; it.cmd_id = id; it.prio_class = c; it.ready_level = lv; it.now_ms = now;
    send_event(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_timeout(logic [31:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.tmo = v;
  endtask

  // mostly well-formed traffic over a small id pool, some noise
  task automatic random_event();
    int r;
    logic [15:0] id;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(1500);
    id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
    if (r < 45)
      ev(FUNC_SUBMIT, id, ($urandom_range(19) == 0) ? CLS_INVALID : 2'($urandom_range(2)),
         1'($urandom), clock_ms);
    else if (r < 65) begin
      if (board.b_n > 0 && $urandom_range(3) != 0) id = board.b_id[$urandom_range(board.b_n - 1)];
      ev(FUNC_RESPONSE, id, 2'($urandom), 1'($urandom), clock_ms);
    end else if (r < 82)
      ev(FUNC_TICK, 16'($urandom), 2'($urandom), 1'($urandom), clock_ms);
    else if (r < 93)
      ev(FUNC_READY, 16'($urandom), 2'($urandom), 1'($urandom), clock_ms);
    else if (r < 97)
      ev(FUNC_CANCEL, 16'($urandom), 2'($urandom), 1'($urandom), 32'($urandom));
    else
      ev(3'($urandom_range(7, 5)), 16'($urandom), 2'($urandom), 1'($urandom), 32'($urandom));
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: classes, duplicates, gate, extremes
    ev(FUNC_SUBMIT, 16'h0000, CLS_QUEUED, 0, 32'd0);
    ev(FUNC_SUBMIT, 16'hFFFF, CLS_FASTPASS, 1, 32'hFFFF_FFFF);
    ev(FUNC_SUBMIT, 16'hFFFF, CLS_FASTPASS, 0, 32'd5);  // duplicate in flight
    ev(FUNC_SUBMIT, 16'h0000, CLS_KEEPALIVE, 0, 32'd6); // duplicate waiting
    ev(FUNC_SUBMIT, 16'h1234, CLS_INVALID, 0, 32'd7);
    ev(FUNC_SUBMIT, 16'h0001, CLS_QUEUED, 0, 32'd8);
    ev(FUNC_READY, 16'd0, 2'd0, 1, 32'd9);
    ev(FUNC_RESPONSE, 16'h0000, 2'd0, 0, 32'd10);
    ev(FUNC_RESPONSE, 16'h7777, 2'd0, 0, 32'd11);       // no match
    ev(FUNC_TICK, 16'd0, 2'd0, 0, 32'd2000);
    ev(FUNC_TICK, 16'hFFFF, 2'd3, 1, 32'd4000);         // wraps against the max sent time
    ev(FUNC_READY, 16'd0, 2'd0, 0, 32'd0);
    // fill both tables, then overflow the wait list
    for (int i = 0; i < 26; i++) ev(FUNC_SUBMIT, 16'(100 + i), 2'(i % 3), 0, 32'd50);
    ev(FUNC_READY, 16'd0, 2'd0, 1, 32'd60);
    ev(FUNC_CANCEL, 16'd0, 2'd0, 0, 32'd0);
    ev(3'd7, 16'hFFFF, 2'd3, 1, 32'hFFFF_FFFF);
    ev(3'd5, 16'd0, 2'd0, 0, 32'd0);

    // zero timeout: everything expires each tick
    set_timeout(32'd0);
    for (int i = 0; i < 4; i++) ev(FUNC_SUBMIT, 16'(i), CLS_FASTPASS, 0, 32'd3);
    ev(FUNC_TICK, 16'd0, 2'd0, 0, 32'd3);

    for (int n = 0; n < 420; n++) begin
      if (n == 100) set_timeout(32'hFFFF_FFFF);
      if (n == 200) set_timeout(32'd1);
      if (n == 300) set_timeout(32'd2500);
      if (n == 150) calm = 1;
      if (n == 230) calm = 0;
      if (n == 260) hold_cycles = 400;   // receiver holds off, sender keeps offering
      if (n == 350) drain();             // sender pauses until all results are in
      random_event();
    end

    drain();
    $display("covered %0d events, %0d results, timeout settings 0, 1, 2500, max and reset",
             sent_items, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
